// ===== src/ssst_pkg.sv =====
// ssst_pkg: shared codes and constants for the sorted sprite slot table
// no dependencies
package ssst_pkg;

    localparam int PRIO_W = 8;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_SETP  = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_HANDLE = 2'd1;
    localparam logic [1:0] ST_BAD       = 2'd2;

    localparam logic [15:0] HIDDEN_WORD = 16'h0200;

    // top two priority bits placed at bits 11..10 of attribute word 2
    function automatic logic [15:0] prio_field(input logic [PRIO_W-1:0] p);
        prio_field = {4'b0000, p[7:6], 10'b0};
    endfunction

endpackage

// ===== src/ssst_cell.sv =====
// ssst_cell: one slot of the rotating table, holds owner handle and priority
// depends on ssst_pkg
module ssst_cell
    import ssst_pkg::*;
#(
    parameter int HW = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic [HW-1:0]     i_handle,
    input  logic [PRIO_W-1:0] i_prio,
    output logic [HW-1:0]     o_handle,
    output logic [PRIO_W-1:0] o_prio
);

    logic [HW-1:0]     r_handle;
    logic [PRIO_W-1:0] r_prio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handle <= '0;
            r_prio   <= '0;
        end else if (i_shift) begin
            r_handle <= i_handle;
            r_prio   <= i_prio;
        end
    end

    assign o_handle = r_handle;
    assign o_prio   = r_prio;

endmodule

// ===== src/sorted_sprite_slot_table.sv =====
// sorted_sprite_slot_table: top level, ring of slot cells and the stream unit at its head
// depends on ssst_pkg and ssst_cell
//
// Every item passes through these steps: the stored priority of the handle is read and the
// operation decided as the item is taken, the decision is completed in the prep state, then the
// ring of cells rotates once through the unit at its head, which drops, inserts or reads one
// slot per cycle, and finally the result register is loaded. One item is worked on at a time;
// a new item is taken while the previous result still waits in the output register.
module sorted_sprite_slot_table
    import ssst_pkg::*;
#(
    parameter int SLOTS = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_priority_req,
    input  logic [6:0]  i_handle,
    input  logic [6:0]  i_slot,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_status,
    output logic [6:0]  o_handle_out,
    output logic [6:0]  o_slot_out,
    output logic [7:0]  o_entry_count,
    output logic        o_empty_res,
    output logic [15:0] o_attr_zero,
    output logic [15:0] o_attr_one,
    output logic [15:0] o_attr_two,
    output logic [7:0]  o_entry_priority
);

    localparam int HW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        r_state;
    logic [HW-1:0]     r_t;
    logic [CW-1:0]     r_count;
    logic [SLOTS-1:0]  r_free;
    logic [HW-1:0]     r_next_free;
    logic              r_has_free;
    logic              r_nf_found;
    logic [HW-1:0]     r_nf_scan;

    logic [1:0]        r_mode;
    logic [PRIO_W-1:0] r_prio;
    logic [6:0]        r_hin;
    logic [6:0]        r_sl;
    logic              r_h_ok;
    logic [PRIO_W-1:0] r_old_prio;
    logic [PRIO_W-1:0] r_prio_mem [SLOTS];

    logic [1:0]        r_err;
    logic              r_rem;
    logic              r_ins;
    logic              r_up;
    logic [HW-1:0]     r_eh;
    logic              r_rmseen;
    logic              r_insdone;
    logic [HW-1:0]     r_idx;
    logic [HW-1:0]     r_p;
    logic [HW-1:0]     r_pend_h;
    logic [PRIO_W-1:0] r_pend_p;
    logic              r_rd_live;
    logic [HW-1:0]     r_rd_h;
    logic [PRIO_W-1:0] r_rd_p;

    logic              r_ovalid;
    logic [1:0]        r_o_status;
    logic [6:0]        r_o_handle;
    logic [6:0]        r_o_slot;
    logic [7:0]        r_o_count;
    logic [15:0]       r_o_a0;
    logic [15:0]       r_o_a2;
    logic [7:0]        r_o_ep;

    logic [HW-1:0]     c_h [SLOTS];
    logic [PRIO_W-1:0] c_p [SLOTS];
    logic [HW-1:0]     y_h;
    logic [PRIO_W-1:0] y_p;
    logic              shift;

    logic              in_acc;
    logic              live0;
    logic              hit0;
    logic              rm_now;
    logic              s_valid;
    logic [HW-1:0]     s_h;
    logic [PRIO_W-1:0] s_p;
    logic              cond;
    logic              ins_now;
    logic              run_last;
    logic              load_out;
    logic [HW-1:0]     h_idx;
    logic              post_free;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign shift      = (r_state == S_RUN);
    assign run_last   = shift && (32'(r_t) == SLOTS - 1);
    assign load_out   = (r_state == S_FIN) && (!r_ovalid || i_out_ready);
    assign h_idx      = HW'(r_hin);

    for (genvar g = 0; g < SLOTS; g++) begin : g_ring
        if (g == SLOTS - 1) begin : g_tail
            ssst_cell #(.HW(HW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_handle(y_h),
                .i_prio  (y_p),
                .o_handle(c_h[g]),
                .o_prio  (c_p[g])
            );
        end else begin : g_body
            ssst_cell #(.HW(HW)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_handle(c_h[g+1]),
                .i_prio  (c_p[g+1]),
                .o_handle(c_h[g]),
                .o_prio  (c_p[g])
            );
        end
    end

    // stream unit at the ring head
    always_comb begin
        live0   = 32'(r_t) < 32'(r_count);
        hit0    = live0 && (c_h[0] == h_idx);
        rm_now  = r_rem && (r_rmseen || hit0);
        s_valid = rm_now ? (32'(r_t) + 1 < 32'(r_count)) : live0;
        s_h     = '0;
        s_p     = '0;
        if (s_valid) begin
            s_h = rm_now ? c_h[1] : c_h[0];
            s_p = rm_now ? c_p[1] : c_p[0];
        end
        if (!s_valid) begin
            cond = 1'b1;
        end else if (r_up) begin
            cond = s_p > r_prio;
        end else begin
            cond = s_p >= r_prio;
        end
        ins_now = r_ins && !r_insdone && cond;
        if (r_insdone) begin
            y_h = r_pend_h;
            y_p = r_pend_p;
        end else if (ins_now) begin
            y_h = r_eh;
            y_p = r_prio;
        end else begin
            y_h = s_h;
            y_p = s_p;
        end
        post_free = r_free[r_t];
    end

    // priority store per handle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_old_prio <= r_prio_mem[HW'(i_handle)];
        end
        if (r_state == S_PREP && r_err == ST_OK && r_ins) begin
            r_prio_mem[r_eh] <= r_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_t         <= '0;
            r_count     <= '0;
            r_free      <= '1;
            r_next_free <= '0;
            r_has_free  <= 1'b1;
            r_nf_found  <= 1'b0;
            r_nf_scan   <= '0;
            r_err       <= ST_OK;
            r_rem       <= 1'b0;
            r_ins       <= 1'b0;
            r_up        <= 1'b0;
            r_rmseen    <= 1'b0;
            r_insdone   <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_t        <= '0;
                    r_rmseen   <= 1'b0;
                    r_insdone  <= 1'b0;
                    r_nf_found <= 1'b0;
                    r_state    <= S_RUN;
                end
                S_RUN: begin
                    r_t <= r_t + 1'b1;
                    if (r_rem && hit0) begin
                        r_rmseen <= 1'b1;
                    end
                    if (ins_now) begin
                        r_insdone <= 1'b1;
                    end
                    if (post_free && !r_nf_found) begin
                        r_nf_found <= 1'b1;
                        r_nf_scan  <= r_t;
                    end
                    if (run_last) begin
                        r_has_free <= r_nf_found || post_free;
                        r_next_free <= r_nf_found ? r_nf_scan : r_t;
                        if (r_err == ST_OK && r_mode == MODE_ALLOC) begin
                            r_count <= r_count + 1'b1;
                        end else if (r_err == ST_OK && r_mode == MODE_FREE) begin
                            r_count <= r_count - 1'b1;
                        end
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // decision stage
            if (r_state == S_IDLE && in_acc) begin
                r_err <= ST_OK;
                r_rem <= 1'b0;
                r_ins <= 1'b0;
                r_up  <= 1'b0;
                case (i_mode)
                    MODE_ALLOC: begin
                        if (!r_has_free || 32'(r_count) >= SLOTS) begin
                            r_err <= ST_NO_HANDLE;
                        end else begin
                            r_ins <= 1'b1;
                        end
                    end
                    MODE_SETP, MODE_FREE: begin
                        if (32'(i_handle) >= SLOTS || r_free[HW'(i_handle)]) begin
                            r_err <= ST_BAD;
                        end else begin
                            r_rem <= 1'b1;
                            r_ins <= (i_mode == MODE_SETP);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_state == S_PREP && r_err == ST_OK) begin
                if (r_mode == MODE_SETP) begin
                    if (r_old_prio == r_prio) begin
                        r_rem <= 1'b0;
                        r_ins <= 1'b0;
                    end
                    r_up <= r_prio < r_old_prio;
                end
                if (r_mode == MODE_ALLOC) begin
                    r_free[r_next_free] <= 1'b0;
                end
                if (r_mode == MODE_FREE) begin
                    r_free[h_idx] <= 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode <= i_mode;
            r_prio <= i_priority_req;
            r_hin  <= i_handle;
            r_sl   <= i_slot;
            r_h_ok <= 32'(i_handle) < SLOTS;
            r_eh   <= (i_mode == MODE_ALLOC) ? r_next_free : HW'(i_handle);
        end
        if (shift) begin
            if (hit0) begin
                r_idx <= r_t;
            end
            if (ins_now) begin
                r_p <= r_t;
            end
            if (r_insdone || ins_now) begin
                r_pend_h <= s_h;
                r_pend_p <= s_p;
            end
            if (32'(r_t) == 32'(r_sl)) begin
                r_rd_live <= live0;
                r_rd_h    <= c_h[0];
                r_rd_p    <= c_p[0];
            end
        end
        if (load_out) begin
            r_o_status <= r_err;
            r_o_handle <= '0;
            r_o_slot   <= '0;
            r_o_count  <= 8'(r_count);
            r_o_a0     <= '0;
            r_o_a2     <= '0;
            r_o_ep     <= '0;
            case (r_mode)
                MODE_ALLOC: begin
                    if (r_err == ST_OK) begin
                        r_o_handle <= 7'(r_eh);
                        r_o_slot   <= 7'(r_p);
                    end
                end
                MODE_SETP: begin
                    r_o_handle <= r_hin;
                    if (r_err == ST_OK) begin
                        r_o_slot <= r_ins ? 7'(r_p) : 7'(r_idx);
                    end
                end
                MODE_FREE: begin
                    r_o_handle <= r_hin;
                    if (r_err == ST_OK) begin
                        r_o_slot <= 7'(r_idx);
                    end
                end
                default: begin
                    r_o_slot <= r_sl;
                    if (32'(r_sl) < SLOTS) begin
                        r_o_a0 <= HIDDEN_WORD;
                    end
                    if (r_rd_live && 32'(r_sl) < SLOTS) begin
                        r_o_status <= ST_OK;
                        r_o_handle <= 7'(r_rd_h);
                        r_o_a2     <= prio_field(r_rd_p);
                        r_o_ep     <= r_rd_p;
                    end else begin
                        r_o_status <= ST_BAD;
                    end
                end
            endcase
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_status         = r_o_status;
    assign o_handle_out     = r_o_handle;
    assign o_slot_out       = r_o_slot;
    assign o_entry_count    = r_o_count;
    assign o_empty_res      = (r_o_count == '0);
    assign o_attr_zero      = r_o_a0;
    assign o_attr_one       = '0;
    assign o_attr_two       = r_o_a2;
    assign o_entry_priority = r_o_ep;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= SLOTS)
        else $error("entry count above table size");

    a_insert_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_err == ST_OK && r_ins) |-> r_insdone)
        else $error("insertion never placed");

    a_pass_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_last |=> (r_state == S_FIN))
        else $error("rotation pass did not close");

    a_hold_h_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_mode == MODE_FREE && r_err == ST_OK) |-> r_h_ok)
        else $error("free of out of range handle");

endmodule

// ===== tb/ssst_checker.sv =====
// ssst_checker: watches both channels of the sorted sprite slot table, predicts every result
// from its own copy of the table and compares field by field; depends on ssst_pkg
module ssst_checker
    import ssst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [7:0]  i_priority_req,
    input  logic [6:0]  i_handle,
    input  logic [6:0]  i_slot,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [6:0]  i_handle_out,
    input  logic [6:0]  i_slot_out,
    input  logic [7:0]  i_entry_count,
    input  logic        i_empty_res,
    input  logic [15:0] i_attr_zero,
    input  logic [15:0] i_attr_one,
    input  logic [15:0] i_attr_two,
    input  logic [7:0]  i_entry_priority,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 128;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  handle_out;
        logic [6:0]  slot_out;
        logic [7:0]  entry_count;
        logic        empty_res;
        logic [15:0] attr_zero;
        logic [15:0] attr_one;
        logic [15:0] attr_two;
        logic [7:0]  entry_priority;
    } t_table_result;

    logic        handle_free [NSLOT];
    logic [6:0]  slot_handle [NSLOT];
    logic [6:0]  handle_slot [NSLOT];
    logic [7:0]  handle_prio [NSLOT];
    logic [15:0] word0 [NSLOT];
    logic [15:0] word1 [NSLOT];
    logic [15:0] word2 [NSLOT];
    int          live;
    t_table_result results_due [$];

    assign o_pending = results_due.size();

    function automatic logic [15:0] prio_bits(input logic [7:0] p);
        return {4'b0000, p[7:6], 10'b0};
    endfunction

    function automatic logic [7:0] slot_prio(input int s);
        return handle_prio[slot_handle[s]];
    endfunction

    task automatic shift_row(input int dst, input int src);
        slot_handle[dst] = slot_handle[src];
        handle_slot[slot_handle[src]] = dst[6:0];
        word0[dst] = word0[src];
        word1[dst] = word1[src];
        word2[dst] = word2[src];
    endtask

    task automatic clear_table();
        for (int i = 0; i < NSLOT; i++) begin
            handle_free[i] = 1'b1;
            slot_handle[i] = '0;
            handle_slot[i] = '0;
            handle_prio[i] = '0;
            word0[i] = HIDDEN_WORD;
            word1[i] = '0;
            word2[i] = '0;
        end
        live = 0;
    endtask

    task automatic apply_op(input logic [1:0] mode, input logic [7:0] prio,
                            input logic [6:0] h, input logic [6:0] sl,
                            output t_table_result r);
        int nh, ins, idx, dst, lim;
        logic [7:0] old;
        logic [15:0] b0, b1, b2;
        r = '0;
        if (mode == MODE_ALLOC) begin
            nh = NSLOT;
            for (int i = NSLOT - 1; i >= 0; i--)
                if (handle_free[i]) nh = i;
            if (nh >= NSLOT || live >= NSLOT) begin
                r.status = ST_NO_HANDLE;
            end else begin
                ins = 0;
                while (ins < live && slot_prio(ins) < prio) ins++;
                for (int i = live; i > ins; i--) shift_row(i, i - 1);
                handle_free[nh] = 1'b0;
                slot_handle[ins] = nh[6:0];
                handle_slot[nh] = ins[6:0];
                handle_prio[nh] = prio;
                word0[ins] = HIDDEN_WORD;
                word1[ins] = '0;
                word2[ins] = prio_bits(prio);
                live++;
                r.handle_out = nh[6:0];
                r.slot_out = ins[6:0];
            end
        end else if (mode == MODE_SETP) begin
            r.handle_out = h;
            if (handle_free[h]) begin
                r.status = ST_BAD;
            end else begin
                old = handle_prio[h];
                idx = handle_slot[h];
                if (old != prio) begin
                    handle_prio[h] = prio;
                    word2[idx] = (word2[idx] & 16'hf3ff) | prio_bits(prio);
                    b0 = word0[idx];
                    b1 = word1[idx];
                    b2 = word2[idx];
                    if (prio < old) begin
                        dst = idx;
                        while (dst > 0 && slot_prio(dst - 1) > prio) dst--;
                        for (int i = idx; i > dst; i--) shift_row(i, i - 1);
                    end else begin
                        lim = idx + 1;
                        while (lim < live && prio > slot_prio(lim)) lim++;
                        for (int i = idx; i + 1 < lim; i++) shift_row(i, i + 1);
                        dst = lim - 1;
                    end
                    slot_handle[dst] = h;
                    handle_slot[h] = dst[6:0];
                    word0[dst] = b0;
                    word1[dst] = b1;
                    word2[dst] = b2;
                    idx = dst;
                end
                r.slot_out = idx[6:0];
            end
        end else if (mode == MODE_FREE) begin
            r.handle_out = h;
            if (handle_free[h] || live == 0) begin
                r.status = ST_BAD;
            end else begin
                idx = handle_slot[h];
                r.slot_out = idx[6:0];
                handle_free[h] = 1'b1;
                live--;
                while (idx < live) begin
                    shift_row(idx, idx + 1);
                    idx++;
                end
                slot_handle[idx] = '0;
                word0[idx] = HIDDEN_WORD;
                word1[idx] = '0;
                word2[idx] = '0;
            end
        end else begin
            r.slot_out = sl;
            r.attr_zero = word0[sl];
            r.attr_one = word1[sl];
            r.attr_two = word2[sl];
            if (sl < live) begin
                r.handle_out = slot_handle[sl];
                r.entry_priority = slot_prio(sl);
            end else begin
                r.status = ST_BAD;
            end
        end
        r.entry_count = live[7:0];
        r.empty_res = (live == 0);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        clear_table();
    end

    always @(posedge i_clk) begin
        t_table_result want, nxt;
        if (!i_rst_n) begin
            clear_table();
            results_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: result with no item outstanding, status %0d", $time,
                             i_status);
                    o_fail_count++;
                end else begin
                    want = results_due.pop_front();
                    compare_field("status", want.status, i_status);
                    compare_field("handle_out", want.handle_out, i_handle_out);
                    compare_field("slot_out", want.slot_out, i_slot_out);
                    compare_field("entry_count", want.entry_count, i_entry_count);
                    compare_field("empty_res", want.empty_res, i_empty_res);
                    compare_field("attr_zero", want.attr_zero, i_attr_zero);
                    compare_field("attr_one", want.attr_one, i_attr_one);
                    compare_field("attr_two", want.attr_two, i_attr_two);
                    compare_field("entry_priority", want.entry_priority, i_entry_priority);
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_op(i_mode, i_priority_req, i_handle, i_slot, nxt);
                results_due.push_back(nxt);
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// tb: drives the sorted sprite slot table with directed and random items under varying
// back-pressure; depends on ssst_pkg, sorted_sprite_slot_table and ssst_checker
module tb;
    import ssst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 6000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_mode = MODE_READ;
    logic [7:0]  i_priority_req = '0;
    logic [6:0]  i_handle = '0;
    logic [6:0]  i_slot = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [6:0]  o_handle_out;
    logic [6:0]  o_slot_out;
    logic [7:0]  o_entry_count;
    logic        o_empty_res;
    logic [15:0] o_attr_zero;
    logic [15:0] o_attr_one;
    logic [15:0] o_attr_two;
    logic [7:0]  o_entry_priority;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_req = 1'b0;
    int quiet_cycles = 0;

    sorted_sprite_slot_table DUT (.*);

    ssst_checker u_checker (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_mode, .i_priority_req,
        .i_handle, .i_slot, .i_out_valid(o_out_valid), .i_out_ready,
        .i_status(o_status), .i_handle_out(o_handle_out), .i_slot_out(o_slot_out),
        .i_entry_count(o_entry_count), .i_empty_res(o_empty_res),
        .i_attr_zero(o_attr_zero), .i_attr_one(o_attr_one), .i_attr_two(o_attr_two),
        .i_entry_priority(o_entry_priority), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver side, including one long hold-off on request
    initial begin
        int held;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_out_ready <= 1'b0;
                held = 1;
                while (held < 700) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_req = 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // called just after a rising edge; offers one item and returns once it is accepted
    task automatic send_item(input logic [1:0] mode, input logic [7:0] prio,
                             input logic [6:0] h, input logic [6:0] sl);
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(negedge i_clk);
        end
        i_mode <= mode;
        i_priority_req <= prio;
        i_handle <= h;
        i_slot <= sl;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_random(input int alloc_pct);
        int pick;
        logic [1:0] mode;
        logic [7:0] prio;
        pick = $urandom_range(99);
        if (pick < alloc_pct) mode = MODE_ALLOC;
        else if (pick < alloc_pct + (100 - alloc_pct) / 3) mode = MODE_SETP;
        else if (pick < alloc_pct + 2 * (100 - alloc_pct) / 3) mode = MODE_FREE;
        else mode = MODE_READ;
        case ($urandom_range(5))
            0: prio = 8'd0;
            1: prio = 8'd255;
            2: prio = 8'($urandom_range(3)) << 6;
            default: prio = 8'($urandom_range(255));
        endcase
        send_item(mode, prio, 7'($urandom_range($urandom_range(127))),
                  7'($urandom_range($urandom_range(127))));
    endtask

    initial begin
        int n;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(MODE_READ, 8'd0, 7'd0, 7'd0);
        send_item(MODE_FREE, 8'd0, 7'd5, 7'd0);
        send_item(MODE_SETP, 8'd9, 7'd5, 7'd0);
        send_item(MODE_ALLOC, 8'd100, 7'd0, 7'd0);
        send_item(MODE_ALLOC, 8'd50, 7'd0, 7'd0);
        send_item(MODE_ALLOC, 8'd150, 7'd0, 7'd0);
        send_item(MODE_ALLOC, 8'd100, 7'd0, 7'd0);
        send_item(MODE_ALLOC, 8'd0, 7'd0, 7'd0);
        send_item(MODE_ALLOC, 8'd255, 7'd0, 7'd0);
        send_item(MODE_SETP, 8'd100, 7'd0, 7'd0);
        send_item(MODE_SETP, 8'd20, 7'd0, 7'd0);
        send_item(MODE_SETP, 8'd200, 7'd1, 7'd0);
        send_item(MODE_SETP, 8'd100, 7'd4, 7'd0);
        send_item(MODE_SETP, 8'd150, 7'd5, 7'd0);
        for (int s = 0; s < 6; s++) send_item(MODE_READ, 8'd0, 7'd0, 7'(s));
        send_item(MODE_READ, 8'hff, 7'h7f, 7'd127);
        send_item(MODE_FREE, 8'd0, 7'd2, 7'd0);
        send_item(MODE_FREE, 8'd0, 7'd2, 7'd0);
        send_item(MODE_ALLOC, 8'd100, 7'd0, 7'd0);
        send_item(MODE_SETP, 8'd1, 7'd127, 7'd0);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 14 : (ph == 1) ? 59 : 0;
            recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 14 : 0;
            for (n = 0; n < 290; n++) begin
                if (ph == 0 && n == 40) hold_req = 1'b1;
                if (ph == 1 && n == 100) begin
                    @(negedge i_clk);
                    i_in_valid <= 1'b0;
                    while (pending != 0) @(negedge i_clk);
                    @(posedge i_clk);
                end
                send_random((n < 145) ? 88 : 35);
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ssst_pkg.sv
src/ssst_cell.sv
src/sorted_sprite_slot_table.sv
tb/ssst_checker.sv
tb/tb.sv
